/* hw/rtl/uafu_pkg.sv */
// shared types, request codes and constants of the usb audio feature unit
`default_nettype none

package uafu_pkg;

    // stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;

    // item modes carried on s_tuser
    localparam logic [1:0] MODE_CTRL = 2'd0;
    localparam logic [1:0] MODE_CAP  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    // request sub-kinds (low two bits of req_kind), bit 2 marks a set
    localparam logic [1:0] SUB_CUR = 2'd0;
    localparam logic [1:0] SUB_MIN = 2'd1;
    localparam logic [1:0] SUB_MAX = 2'd2;
    localparam logic [1:0] SUB_RES = 2'd3;

    // control selectors
    localparam logic [7:0] CS_MUTE       = 8'h01;
    localparam logic [7:0] CS_VOLUME     = 8'h02;
    localparam logic [7:0] CS_BASS_BOOST = 8'h09;
    localparam logic [7:0] CS_RATE       = 8'h01;

    // unit and endpoint addresses
    localparam logic [15:0] TGT_CAP_A  = 16'h0600;
    localparam logic [15:0] TGT_CAP_B  = 16'h0200;
    localparam logic [15:0] TGT_PLAY   = 16'h0100;
    localparam logic [15:0] EP_CAP     = 16'h0084;
    localparam logic [15:0] EP_PLAY    = 16'h0001;

    // fixed volume words
    localparam logic [23:0] VOL_MIN_WORD = 24'h008001;
    localparam logic [23:0] VOL_MAX_WORD = 24'h000800;
    localparam logic [23:0] VOL_RES_WORD = 24'h000088;

    // volume code to word: (v * 0x8800 + 127) / 255 + 0x8000
    localparam logic [15:0] VOL_STEP      = 16'h8800;
    localparam logic [6:0]  VOL_ROUND     = 7'd127;
    localparam logic [15:0] VOL_WORD_BIAS = 16'h8000;

    // word to volume code: ((w - 0x8000) * 255 + 0x4400) / 0x8800
    localparam logic [23:0] VOL_SET_BIAS = 24'h004400;
    localparam logic [12:0] VOL_CLAMP_Y  = 13'd4352;   // 256 * 17
    localparam logic [15:0] RECIP17      = 16'd61681;  // ceil(2^20 / 17)
    localparam logic [7:0]  VOL_MAX_CODE = 8'hFF;

    // reset values
    localparam logic [7:0]  VOL_RESET  = 8'd240;
    localparam logic [23:0] RATE_RESET = 24'd48000;

    // pipeline stage enables
    typedef struct packed {
        logic s1;
        logic a;
        logic b;
        logic c;
        logic d;
    } uafu_en_t;

    // operands of one scaling lane: (a * b + c) / 255, sign applied later
    typedef struct packed {
        logic        neg;
        logic [15:0] a;
        logic [7:0]  b;
        logic [6:0]  c;
    } uafu_lane_in_t;

    typedef struct packed {
        logic        neg;
        logic [15:0] q;
    } uafu_lane_out_t;

    // per-item info that rides alongside the lanes
    typedef struct packed {
        logic        is_ctrl;
        logic        is_cap;
        logic        stall;
        logic [1:0]  len;
        logic [23:0] val;
        logic        vol_cur;
    } uafu_meta_t;

endpackage

`default_nettype wire

/* hw/rtl/usb_audio_feature_unit.sv */
// top level of the usb audio feature unit: request handling and sample scaling
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------
//  s_       | s_tvalid/s_tready | s_tuser mode, s_tdata request and samples
//  m_       | m_tvalid/m_tready | m_tdata reply and scaled samples
//
// five register stages from accept to m_tvalid; one item per cycle while m_tready
// is high; the decode stage updates control state at accept
// two lanes scale left and right; lane 0 also converts a volume code for GET_CUR
// aresetn clears control state and stage valid bits, payload is not reset
// each stage holds while the next one is full and stalled, bubbles collapse
// items that give no result (streaming off, unknown mode) never enter the pipe
`default_nettype none

module usb_audio_feature_unit import uafu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // req_kind, to_endpoint, selector, channel, target, set_value,
    // sample_a, sample_b, stereo, stream_on, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // stall_res, reply_len, reply_value, out_left, out_right, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic v1_reg;
    logic va_reg;
    logic vb_reg;
    logic vc_reg;
    logic vd_reg;

    uafu_en_t       en;
    logic           s_acc;
    logic           has_result;
    uafu_meta_t     meta;
    uafu_lane_in_t  lane0_in;
    uafu_lane_in_t  lane1_in;
    uafu_lane_out_t lane0_out;
    uafu_lane_out_t lane1_out;

    logic        stall_res;
    logic [1:0]  reply_len;
    logic [23:0] reply_value;
    logic [15:0] out_left;
    logic [15:0] out_right;

    // stage enables: a stage moves when it is empty or the next one moves
    always_comb begin
        en.d  = !vd_reg || m_tready;
        en.c  = !vc_reg || en.d;
        en.b  = !vb_reg || en.c;
        en.a  = !va_reg || en.b;
        en.s1 = !v1_reg || en.a;
    end

    assign s_tready = en.s1;
    assign s_acc    = s_tvalid && s_tready;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (en.s1) begin
                v1_reg <= s_acc && has_result;
            end
            if (en.a) begin
                va_reg <= v1_reg;
            end
            if (en.b) begin
                vb_reg <= va_reg;
            end
            if (en.c) begin
                vc_reg <= vb_reg;
            end
            if (en.d) begin
                vd_reg <= vc_reg;
            end
        end
    end

    // decode and control state
    uafu_req u_req (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_acc      (s_acc),
        .en          (en),
        .mode        (s_tuser),
        .req_kind    (s_tdata[2:0]),
        .to_endpoint (s_tdata[3]),
        .selector    (s_tdata[11:4]),
        .channel     (s_tdata[19:12]),
        .target      (s_tdata[35:20]),
        .set_value   (s_tdata[59:36]),
        .sample_a    (s_tdata[75:60]),
        .sample_b    (s_tdata[91:76]),
        .stereo      (s_tdata[92]),
        .stream_on   (s_tdata[93]),
        .has_result  (has_result),
        .meta        (meta),
        .lane0       (lane0_in),
        .lane1       (lane1_in)
    );

    // scaling lanes
    uafu_lane u_lane0 (
        .aclk     (aclk),
        .en       (en),
        .lane_in  (lane0_in),
        .lane_out (lane0_out)
    );

    uafu_lane u_lane1 (
        .aclk     (aclk),
        .en       (en),
        .lane_in  (lane1_in),
        .lane_out (lane1_out)
    );

    // merge and output register
    uafu_merge u_merge (
        .aclk        (aclk),
        .en          (en),
        .meta_in     (meta),
        .lane0       (lane0_out),
        .lane1       (lane1_out),
        .stall_res   (stall_res),
        .reply_len   (reply_len),
        .reply_value (reply_value),
        .out_left    (out_left),
        .out_right   (out_right)
    );

    assign m_tvalid = vd_reg;
    assign m_tdata  = {5'd0, out_right, out_left, reply_value, reply_len, stall_res};

endmodule

`default_nettype wire

/* hw/rtl/uafu_req.sv */
// request decode, control state and lane operand setup (first pipeline stage)
`default_nettype none

module uafu_req import uafu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_acc,
    input  uafu_en_t             en,
    input  logic [1:0]           mode,
    input  logic [2:0]           req_kind,
    input  logic                 to_endpoint,
    input  logic [7:0]           selector,
    input  logic [7:0]           channel,
    input  logic [15:0]          target,
    input  logic [23:0]          set_value,
    input  logic [15:0]          sample_a,
    input  logic [15:0]          sample_b,
    input  logic                 stereo,
    input  logic                 stream_on,
    output logic                 has_result,
    output uafu_meta_t           meta,
    output uafu_lane_in_t        lane0,
    output uafu_lane_in_t        lane1
);

    // control state
    logic        cap_mute_reg;
    logic        play_mute_reg;
    logic [7:0]  cap_vol_reg;
    logic [7:0]  play_vol0_reg;
    logic [7:0]  play_vol1_reg;
    logic [23:0] cap_rate_reg;
    logic [23:0] play_rate_reg;

    // stage registers
    uafu_meta_t    meta_reg;
    uafu_lane_in_t lane0_reg;
    uafu_lane_in_t lane1_reg;

    logic [1:0]  sub;
    logic        is_set;
    logic        ch_ok;
    logic        ch_sel;
    logic        cap;
    logic        play;
    logic        rate_hit;
    logic [15:0] vdiff;
    logic [23:0] wx;
    logic [12:0] wy;
    logic [28:0] wprod;
    logic [7:0]  set_vol;

    logic        c_stall;
    logic [1:0]  c_len;
    logic [23:0] c_val;
    logic        c_vcur;
    logic [7:0]  c_vol;
    logic        wr_rate;
    logic        wr_mute;
    logic        wr_vol;

    logic        sa_neg;
    logic [15:0] sa_mag;
    logic [15:0] sb_src;
    logic        sb_neg;
    logic [15:0] sb_mag;

    uafu_meta_t    meta_next;
    uafu_lane_in_t lane0_next;
    uafu_lane_in_t lane1_next;

    // request fields
    always_comb begin
        sub      = req_kind[1:0];
        is_set   = req_kind[2];
        ch_ok    = (channel == 8'd1) || (channel == 8'd2);
        ch_sel   = (channel == 8'd2);
        cap      = (target == TGT_CAP_A) || (target == TGT_CAP_B);
        play     = (target == TGT_PLAY);
        rate_hit = (selector == CS_RATE) && (sub == SUB_CUR)
                   && ((target == EP_CAP) || (target == EP_PLAY));
    end

    // set word to volume code, divide by 0x8800 as shift by 11 then by 17
    always_comb begin
        vdiff   = {~set_value[15], set_value[14:0]};
        wx      = {vdiff, 8'd0} - {8'd0, vdiff} + VOL_SET_BIAS;
        wy      = wx[23:11];
        wprod   = 29'(wy) * 29'(RECIP17);
        set_vol = (wy >= VOL_CLAMP_Y) ? VOL_MAX_CODE : wprod[27:20];
    end

    // control request decode
    always_comb begin
        c_stall = 1'b1;
        c_len   = 2'd0;
        c_val   = 24'd0;
        c_vcur  = 1'b0;
        c_vol   = cap_vol_reg;
        wr_rate = 1'b0;
        wr_mute = 1'b0;
        wr_vol  = 1'b0;
        if (to_endpoint) begin
            if (rate_hit) begin
                c_stall = 1'b0;
                if (is_set) begin
                    wr_rate = 1'b1;
                end else begin
                    c_len = 2'd3;
                    c_val = (target == EP_CAP) ? cap_rate_reg : play_rate_reg;
                end
            end
        end else if ((cap || play) && !is_set) begin
            if ((selector == CS_MUTE) && (sub == SUB_CUR)) begin
                c_stall = 1'b0;
                c_len   = 2'd1;
                c_val   = {23'd0, cap ? cap_mute_reg : play_mute_reg};
            end else if (selector == CS_VOLUME) begin
                unique case (sub)
                    SUB_MIN: begin
                        c_stall = 1'b0;
                        c_len   = 2'd2;
                        c_val   = VOL_MIN_WORD;
                    end
                    SUB_MAX: begin
                        c_stall = 1'b0;
                        c_len   = 2'd2;
                        c_val   = VOL_MAX_WORD;
                    end
                    SUB_RES: begin
                        c_stall = 1'b0;
                        c_len   = 2'd2;
                        c_val   = VOL_RES_WORD;
                    end
                    SUB_CUR: begin
                        if (cap || ch_ok) begin
                            c_stall = 1'b0;
                            c_len   = 2'd2;
                            c_vcur  = 1'b1;
                            if (!cap) begin
                                c_vol = ch_sel ? play_vol1_reg : play_vol0_reg;
                            end
                        end
                    end
                endcase
            end else if (play && (selector == CS_BASS_BOOST) && (sub == SUB_CUR)) begin
                c_stall = 1'b0;
                c_len   = 2'd1;
            end
        end else if ((cap || play) && (sub == SUB_CUR)) begin
            if (selector == CS_MUTE) begin
                c_stall = 1'b0;
                wr_mute = 1'b1;
            end else if (selector == CS_VOLUME) begin
                if (cap || ch_ok) begin
                    c_stall = 1'b0;
                    wr_vol  = 1'b1;
                end
            end
        end
    end

    // state updates on an accepted control item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_mute_reg  <= 1'b0;
            play_mute_reg <= 1'b0;
            cap_vol_reg   <= VOL_RESET;
            play_vol0_reg <= VOL_RESET;
            play_vol1_reg <= VOL_RESET;
            cap_rate_reg  <= RATE_RESET;
            play_rate_reg <= RATE_RESET;
        end else if (in_acc && (mode == MODE_CTRL)) begin
            if (wr_rate) begin
                if (target == EP_CAP) begin
                    cap_rate_reg <= set_value;
                end else begin
                    play_rate_reg <= set_value;
                end
            end
            if (wr_mute) begin
                if (cap) begin
                    cap_mute_reg <= set_value[0];
                end else begin
                    play_mute_reg <= set_value[0];
                end
            end
            if (wr_vol) begin
                if (cap) begin
                    cap_vol_reg <= set_vol;
                end else if (ch_sel) begin
                    play_vol1_reg <= set_vol;
                end else begin
                    play_vol0_reg <= set_vol;
                end
            end
        end
    end

    // sample magnitudes
    always_comb begin
        sa_neg = sample_a[15];
        sa_mag = sa_neg ? (~sample_a + 16'd1) : sample_a;
        sb_src = stereo ? sample_b : sample_a;
        sb_neg = sb_src[15];
        sb_mag = sb_neg ? (~sb_src + 16'd1) : sb_src;
    end

    // lane operands and item info
    always_comb begin
        has_result = (mode == MODE_CTRL)
                     || (((mode == MODE_CAP) || (mode == MODE_PLAY)) && stream_on);

        meta_next.is_ctrl = (mode == MODE_CTRL);
        meta_next.is_cap  = (mode == MODE_CAP);
        meta_next.stall   = c_stall;
        meta_next.len     = c_len;
        meta_next.val     = c_val;
        meta_next.vol_cur = c_vcur;

        if (mode == MODE_CTRL) begin
            lane0_next.neg = 1'b0;
            lane0_next.a   = VOL_STEP;
            lane0_next.b   = c_vol;
            lane0_next.c   = VOL_ROUND;
        end else begin
            lane0_next.neg = sa_neg;
            lane0_next.a   = sa_mag;
            lane0_next.b   = (mode == MODE_CAP) ? cap_vol_reg : play_vol0_reg;
            lane0_next.c   = 7'd0;
        end

        lane1_next.neg = sb_neg;
        lane1_next.a   = sb_mag;
        lane1_next.b   = play_vol1_reg;
        lane1_next.c   = 7'd0;
    end

    // first stage register
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            meta_reg  <= meta_next;
            lane0_reg <= lane0_next;
            lane1_reg <= lane1_next;
        end
    end

    assign meta  = meta_reg;
    assign lane0 = lane0_reg;
    assign lane1 = lane1_reg;

endmodule

`default_nettype wire

/* hw/rtl/uafu_lane.sv */
// one scaling lane: (a * b + c) / 255 over three stages
`default_nettype none

module uafu_lane import uafu_pkg::*; (
    input  logic           aclk,
    input  uafu_en_t       en,
    input  uafu_lane_in_t  lane_in,
    output uafu_lane_out_t lane_out
);

    logic [23:0] p_a_reg;
    logic        neg_a_reg;
    logic [23:0] p_b_reg;
    logic [15:0] qe_b_reg;
    logic        neg_b_reg;
    logic [15:0] q_c_reg;
    logic        neg_c_reg;

    logic [23:0] p_a_next;
    logic [23:0] sum_b;
    logic [23:0] rem_c;
    logic [15:0] q_c_next;

    // product and rounding offset
    always_comb begin
        p_a_next = 24'(lane_in.a) * 24'(lane_in.b) + 24'(lane_in.c);
    end

    // quotient estimate p/256 * (1 + 1/256 + 1/65536), low by at most one
    always_comb begin
        sum_b = p_a_reg + {8'd0, p_a_reg[23:8]} + {16'd0, p_a_reg[23:16]};
    end

    // correction from the remainder
    always_comb begin
        rem_c    = p_b_reg - {qe_b_reg, 8'd0} + {8'd0, qe_b_reg};
        q_c_next = (rem_c >= 24'd255) ? (qe_b_reg + 16'd1) : qe_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.a) begin
            p_a_reg   <= p_a_next;
            neg_a_reg <= lane_in.neg;
        end
        if (en.b) begin
            p_b_reg   <= p_a_reg;
            qe_b_reg  <= sum_b[23:8];
            neg_b_reg <= neg_a_reg;
        end
        if (en.c) begin
            q_c_reg   <= q_c_next;
            neg_c_reg <= neg_b_reg;
        end
    end

    assign lane_out.q   = q_c_reg;
    assign lane_out.neg = neg_c_reg;

endmodule

`default_nettype wire

/* hw/rtl/uafu_merge.sv */
// item info delay line and merge of lane results into the output register
`default_nettype none

module uafu_merge import uafu_pkg::*; (
    input  logic           aclk,
    input  uafu_en_t       en,
    input  uafu_meta_t     meta_in,
    input  uafu_lane_out_t lane0,
    input  uafu_lane_out_t lane1,
    output logic           stall_res,
    output logic [1:0]     reply_len,
    output logic [23:0]    reply_value,
    output logic [15:0]    out_left,
    output logic [15:0]    out_right
);

    uafu_meta_t  meta_a_reg;
    uafu_meta_t  meta_b_reg;
    uafu_meta_t  meta_c_reg;

    logic        stall_reg;
    logic [1:0]  len_reg;
    logic [23:0] val_reg;
    logic [15:0] left_reg;
    logic [15:0] right_reg;

    logic        stall_next;
    logic [1:0]  len_next;
    logic [23:0] val_next;
    logic [15:0] left_next;
    logic [15:0] right_next;
    logic [15:0] s0;
    logic [15:0] s1;

    // keep item info in step with the lanes
    always_ff @(posedge aclk) begin
        if (en.a) begin
            meta_a_reg <= meta_in;
        end
        if (en.b) begin
            meta_b_reg <= meta_a_reg;
        end
        if (en.c) begin
            meta_c_reg <= meta_b_reg;
        end
    end

    // sign restore and result select
    always_comb begin
        s0 = lane0.neg ? (~lane0.q + 16'd1) : lane0.q;
        s1 = lane1.neg ? (~lane1.q + 16'd1) : lane1.q;
        if (meta_c_reg.is_ctrl) begin
            stall_next = meta_c_reg.stall;
            len_next   = meta_c_reg.len;
            val_next   = meta_c_reg.vol_cur ? {8'd0, lane0.q + VOL_WORD_BIAS}
                                            : meta_c_reg.val;
            left_next  = 16'd0;
            right_next = 16'd0;
        end else begin
            stall_next = 1'b0;
            len_next   = 2'd0;
            val_next   = 24'd0;
            left_next  = s0;
            right_next = meta_c_reg.is_cap ? 16'd0 : s1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en.d) begin
            stall_reg <= stall_next;
            len_reg   <= len_next;
            val_reg   <= val_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign stall_res   = stall_reg;
    assign reply_len   = len_reg;
    assign reply_value = val_reg;
    assign out_left    = left_reg;
    assign out_right   = right_reg;

endmodule

`default_nettype wire

/* tb/usb_audio_feature_unit_tb.sv */
// testbench of the usb audio feature unit: directed table, random requests and samples
`timescale 1ns / 1ps

module usb_audio_feature_unit_tb;
    import uafu_pkg::*;

    // request kinds: low two bits are the sub-kind, bit 2 marks a set
    localparam logic [2:0] GET_CUR = {1'b0, SUB_CUR};
    localparam logic [2:0] GET_MIN = {1'b0, SUB_MIN};
    localparam logic [2:0] GET_MAX = {1'b0, SUB_MAX};
    localparam logic [2:0] GET_RES = {1'b0, SUB_RES};
    localparam logic [2:0] SET_CUR = {1'b1, SUB_CUR};
    localparam logic [2:0] SET_MIN = {1'b1, SUB_MIN};
    localparam logic [2:0] SET_RES = {1'b1, SUB_RES};
    localparam logic [1:0] MODE_NONE = 2'd3;

    // random items that give a result; about one in eleven random items gives none
    localparam int RANDOM_ITEMS = 1020;
    localparam int MAX_PRINTS   = 40;

    // one input item, field by field
    typedef struct {
        logic [1:0]         mode;
        logic [2:0]         req_kind;
        logic               to_ep;
        logic [7:0]         selector;
        logic [7:0]         channel;
        logic [15:0]        target;
        logic [23:0]        set_value;
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic               stereo;
        logic               stream_on;
    } fu_item_t;

    // one result item
    typedef struct {
        logic               stall;
        logic [1:0]         len;
        logic [23:0]        value;
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } fu_reply_t;

    typedef struct {
        fu_item_t  item;
        bit        typed;
        fu_reply_t want;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // headset state as the block should hold it
    logic        cap_mute  = 1'b0;
    logic        play_mute = 1'b0;
    logic [7:0]  cap_vol   = VOL_RESET;
    logic [7:0]  play_vol [2] = '{VOL_RESET, VOL_RESET};
    logic [23:0] cap_rate  = RATE_RESET;
    logic [23:0] play_rate = RATE_RESET;

    fu_reply_t owed_replies [$];
    int        mismatch_count = 0;
    int        send_calm = 0;

    usb_audio_feature_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20000000;
        $display("usb_audio_feature_unit_tb: done, errors");
        $finish;
    end

    // volume code to the 16-bit usb word
    function automatic logic [15:0] code_to_word(logic [7:0] v);
        int unsigned t;
        t = (32'(v) * 32'h8800 + 32'd127) / 32'd255 + 32'h8000;
        return t[15:0];
    endfunction

    // usb word to volume code, clamped
    function automatic logic [7:0] word_to_code(logic [15:0] w);
        logic [15:0] d;
        int unsigned q;
        d = w - 16'h8000;
        q = (32'(d) * 32'd255 + 32'h4400) / 32'h8800;
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    // sample times volume/255, truncating toward zero
    function automatic logic signed [15:0] scale_sample(logic signed [15:0] s, logic [7:0] v);
        int r;
        r = (int'(s) * int'({24'd0, v})) / 255;
        return r[15:0];
    endfunction

    function automatic fu_reply_t reply(logic stall, logic [1:0] len, logic [23:0] value);
        fu_reply_t r;
        r = '{default: '0};
        r.stall = stall;
        r.len = len;
        r.value = value;
        return r;
    endfunction

    function automatic fu_item_t ctrl_req(logic [2:0] kind, logic ep, logic [7:0] sel,
                                          logic [7:0] ch, logic [15:0] tgt, logic [23:0] data);
        fu_item_t it;
        it = '{default: '0};
        it.mode = MODE_CTRL;
        it.req_kind = kind;
        it.to_ep = ep;
        it.selector = sel;
        it.channel = ch;
        it.target = tgt;
        it.set_value = data;
        return it;
    endfunction

    function automatic fu_item_t sample_item(logic [1:0] mode, logic signed [15:0] a,
                                             logic signed [15:0] b, logic st, logic on);
        fu_item_t it;
        it = '{default: '0};
        it.mode = mode;
        it.sample_a = a;
        it.sample_b = b;
        it.stereo = st;
        it.stream_on = on;
        return it;
    endfunction

    // response of the headset to one item; updates the held state
    function automatic bit headset_respond(fu_item_t it, output fu_reply_t r);
        logic [1:0] sub;
        logic       is_set;
        logic [7:0] chi;
        logic       cap;
        logic       play;
        r = reply(1'b1, 2'd0, 24'd0);
        if (it.mode == MODE_CTRL) begin
            sub = it.req_kind[1:0];
            is_set = it.req_kind[2];
            chi = it.channel - 8'd1;
            if (it.to_ep) begin
                // sampling frequency of either endpoint
                if (it.selector == CS_RATE && sub == SUB_CUR &&
                    (it.target == EP_CAP || it.target == EP_PLAY)) begin
                    r.stall = 1'b0;
                    if (is_set) begin
                        if (it.target == EP_CAP) cap_rate = it.set_value;
                        else play_rate = it.set_value;
                    end else begin
                        r.len = 2'd3;
                        r.value = (it.target == EP_CAP) ? cap_rate : play_rate;
                    end
                end
            end else begin
                cap = (it.target == TGT_CAP_A || it.target == TGT_CAP_B);
                play = (it.target == TGT_PLAY);
                if ((cap || play) && !is_set) begin
                    if (it.selector == CS_MUTE && sub == SUB_CUR) begin
                        r = reply(1'b0, 2'd1, {23'd0, cap ? cap_mute : play_mute});
                    end else if (it.selector == CS_VOLUME) begin
                        case (sub)
                            SUB_MIN: r = reply(1'b0, 2'd2, VOL_MIN_WORD);
                            SUB_MAX: r = reply(1'b0, 2'd2, VOL_MAX_WORD);
                            SUB_RES: r = reply(1'b0, 2'd2, VOL_RES_WORD);
                            default: begin
                                if (cap)
                                    r = reply(1'b0, 2'd2, {8'd0, code_to_word(cap_vol)});
                                else if (chi < 8'd2)
                                    r = reply(1'b0, 2'd2,
                                              {8'd0, code_to_word(play_vol[chi[0]])});
                            end
                        endcase
                    end else if (play && it.selector == CS_BASS_BOOST && sub == SUB_CUR) begin
                        r = reply(1'b0, 2'd1, 24'd0);
                    end
                end else if ((cap || play) && sub == SUB_CUR) begin
                    if (it.selector == CS_MUTE) begin
                        r.stall = 1'b0;
                        if (cap) cap_mute = it.set_value[0];
                        else play_mute = it.set_value[0];
                    end else if (it.selector == CS_VOLUME) begin
                        if (cap) begin
                            r.stall = 1'b0;
                            cap_vol = word_to_code(it.set_value[15:0]);
                        end else if (chi < 8'd2) begin
                            r.stall = 1'b0;
                            play_vol[chi[0]] = word_to_code(it.set_value[15:0]);
                        end
                    end
                end
            end
            return 1'b1;
        end
        if (it.mode == MODE_NONE || !it.stream_on)
            return 1'b0;
        r = reply(1'b0, 2'd0, 24'd0);
        if (it.mode == MODE_CAP) begin
            r.out_left = scale_sample(it.sample_a, cap_vol);
            return 1'b1;
        end
        r.out_left = scale_sample(it.sample_a, play_vol[0]);
        r.out_right = scale_sample(it.stereo ? it.sample_b : it.sample_a, play_vol[1]);
        return 1'b1;
    endfunction

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] corner_sample();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // random item: mostly well-formed requests and live samples, some noise
    function automatic fu_item_t random_item();
        fu_item_t it;
        int pick;
        it.mode = 2'($urandom);
        it.req_kind = 3'($urandom);
        it.to_ep = 1'($urandom);
        it.selector = 8'($urandom);
        it.channel = 8'($urandom);
        it.target = 16'($urandom);
        it.set_value = 24'($urandom);
        it.sample_a = 16'($urandom);
        it.sample_b = 16'($urandom);
        it.stereo = 1'($urandom);
        it.stream_on = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.mode = MODE_CTRL;
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 2) != 0) it.req_kind[1:0] = SUB_CUR;
                case ($urandom_range(0, 4))
                    0: it.target = TGT_CAP_A;
                    1: it.target = TGT_CAP_B;
                    2, 3: it.target = TGT_PLAY;
                    default: it.target = $urandom_range(0, 1) ? EP_CAP : EP_PLAY;
                endcase
                it.to_ep = (it.target == EP_CAP || it.target == EP_PLAY);
                case ($urandom_range(0, 3))
                    0: it.selector = CS_MUTE;
                    1, 2: it.selector = CS_VOLUME;
                    default: it.selector = it.to_ep ? CS_RATE : CS_BASS_BOOST;
                endcase
                if ($urandom_range(0, 9) != 0) it.channel = 8'($urandom_range(1, 2));
                // keep volume words mostly inside the usable range
                if ($urandom_range(0, 1) != 0)
                    it.set_value[15:0] = 16'h8000 + 16'($urandom_range(0, 16'h8800));
            end
        end else if (pick < 92) begin
            it.mode = $urandom_range(0, 1) ? MODE_CAP : MODE_PLAY;
            it.stream_on = ($urandom_range(0, 15) != 0);
            if ($urandom_range(0, 9) == 0) it.sample_a = corner_sample();
            if ($urandom_range(0, 9) == 0) it.sample_b = corner_sample();
        end else if ($urandom_range(0, 1) != 0) begin
            it.mode = MODE_NONE;
        end
        return it;
    endfunction

    // offer one item, wait for acceptance, then owe its reply if it gives one
    task automatic send_item(input fu_item_t it, input bit typed, input fu_reply_t want,
                             output bit produced);
        int gap;
        fu_reply_t r;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else if ($urandom_range(0, 199) == 0) begin
            send_calm = $urandom_range(30, 120);
            gap = 0;
        end else begin
            gap = idle_len();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {2'b00, it.stream_on, it.stereo, it.sample_b, it.sample_a, it.set_value,
                    it.target, it.channel, it.selector, it.to_ep, it.req_kind};
        do @(posedge aclk); while (!s_tready);
        produced = headset_respond(it, r);
        if (produced)
            owed_replies.push_back(typed ? want : r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // stimulus: directed table, then random items
    initial begin : source
        plan_row_t plan [$];
        fu_reply_t none;
        bit        produced;
        int        counted;
        none = reply(1'b0, 2'd0, 24'd0);
        // volume 240 reads back as word 0x0000
        plan.push_back('{ctrl_req(GET_CUR, 1'b0, CS_VOLUME, 8'd1, TGT_CAP_A, 24'd0),
                         1'b1, reply(1'b0, 2'd2, 24'h000000)});
        plan.push_back('{ctrl_req(GET_CUR, 1'b0, CS_VOLUME, 8'd2, TGT_PLAY, 24'd0),
                         1'b1, reply(1'b0, 2'd2, 24'h000000)});
        plan.push_back('{ctrl_req(GET_MIN, 1'b0, CS_VOLUME, 8'd1, TGT_PLAY, 24'd0),
                         1'b1, reply(1'b0, 2'd2, VOL_MIN_WORD)});
        plan.push_back('{ctrl_req(GET_MAX, 1'b0, CS_VOLUME, 8'd1, TGT_CAP_B, 24'd0),
                         1'b1, reply(1'b0, 2'd2, VOL_MAX_WORD)});
        plan.push_back('{ctrl_req(GET_RES, 1'b0, CS_VOLUME, 8'hFF, TGT_PLAY, 24'd0),
                         1'b1, reply(1'b0, 2'd2, VOL_RES_WORD)});
        plan.push_back('{ctrl_req(GET_CUR, 1'b0, CS_MUTE, 8'd1, TGT_CAP_B, 24'd0),
                         1'b1, reply(1'b0, 2'd1, 24'd0)});
        plan.push_back('{ctrl_req(GET_CUR, 1'b0, CS_BASS_BOOST, 8'd1, TGT_PLAY, 24'd0),
                         1'b1, reply(1'b0, 2'd1, 24'd0)});
        plan.push_back('{ctrl_req(GET_CUR, 1'b1, CS_RATE, 8'd0, EP_CAP, 24'd0),
                         1'b1, reply(1'b0, 2'd3, RATE_RESET)});
        plan.push_back('{ctrl_req(SET_MIN, 1'b0, CS_VOLUME, 8'd1, TGT_CAP_A, 24'h008000),
                         1'b1, reply(1'b1, 2'd0, 24'd0)});
        // capture volume clamps to 255, channel field ignored
        plan.push_back('{ctrl_req(SET_CUR, 1'b0, CS_VOLUME, 8'd200, TGT_CAP_A, 24'hFF7FFF),
                         1'b0, none});
        plan.push_back('{sample_item(MODE_CAP, 16'sh7FFF, 16'sh0000, 1'b0, 1'b1), 1'b0, none});
        plan.push_back('{sample_item(MODE_CAP, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1), 1'b0, none});
        // left playback volume to zero
        plan.push_back('{ctrl_req(SET_CUR, 1'b0, CS_VOLUME, 8'd1, TGT_PLAY, 24'h008000),
                         1'b0, none});
        plan.push_back('{sample_item(MODE_PLAY, 16'sh8000, 16'sh1234, 1'b0, 1'b1), 1'b0, none});
        plan.push_back('{sample_item(MODE_PLAY, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1), 1'b0, none});
        // streaming off and unknown mode give nothing
        plan.push_back('{sample_item(MODE_PLAY, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0), 1'b0, none});
        plan.push_back('{sample_item(MODE_NONE, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1), 1'b0, none});
        // playback channels other than 1 and 2 stall
        plan.push_back('{ctrl_req(SET_CUR, 1'b0, CS_VOLUME, 8'd3, TGT_PLAY, 24'h000000),
                         1'b1, reply(1'b1, 2'd0, 24'd0)});
        plan.push_back('{ctrl_req(GET_CUR, 1'b0, CS_VOLUME, 8'd0, TGT_PLAY, 24'd0),
                         1'b1, reply(1'b1, 2'd0, 24'd0)});
        plan.push_back('{ctrl_req(SET_CUR, 1'b0, CS_MUTE, 8'd1, TGT_PLAY, 24'hFFFFFF),
                         1'b0, none});
        plan.push_back('{ctrl_req(GET_CUR, 1'b0, CS_MUTE, 8'd1, TGT_PLAY, 24'd0), 1'b0, none});
        plan.push_back('{ctrl_req(SET_CUR, 1'b1, CS_RATE, 8'd1, EP_PLAY, 24'hFFFFFF),
                         1'b0, none});
        plan.push_back('{ctrl_req(GET_CUR, 1'b1, CS_RATE, 8'd1, EP_PLAY, 24'd0), 1'b0, none});
        // unknown selector and target, unsupported set on an endpoint
        plan.push_back('{ctrl_req(GET_CUR, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF),
                         1'b1, reply(1'b1, 2'd0, 24'd0)});
        plan.push_back('{ctrl_req(SET_RES, 1'b1, CS_RATE, 8'd1, EP_CAP, 24'h00BB80),
                         1'b1, reply(1'b1, 2'd0, 24'd0)});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (plan[i])
            send_item(plan[i].item, plan[i].typed, plan[i].want, produced);
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            send_item(random_item(), 1'b0, none, produced);
            if (produced) counted++;
        end
        s_tvalid <= 1'b0;

        // drain, then give the pipe time to show any stray item
        while (owed_replies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("usb_audio_feature_unit_tb: done, clean");
        else
            $display("usb_audio_feature_unit_tb: done, errors");
        $finish;
    end

    // result side ready: bursts of ready with random stalls
    initial begin : sink_ready
        int hold;
        int gap;
        repeat (12) @(posedge aclk);
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (hold) @(posedge aclk);
            gap = idle_len();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // compare each result item with the oldest owed reply
    always @(posedge aclk) begin : watch
        fu_reply_t got;
        fu_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.stall = m_tdata[0];
            got.len = m_tdata[2:1];
            got.value = m_tdata[26:3];
            got.out_left = m_tdata[42:27];
            got.out_right = m_tdata[58:43];
            if (owed_replies.size() == 0) begin
                report_mismatch("result item with nothing owed", m_tdata[31:0], 32'd0);
            end else begin
                want = owed_replies.pop_front();
                if (got.stall !== want.stall)
                    report_mismatch("stall_res", 32'(got.stall), 32'(want.stall));
                if (got.len !== want.len)
                    report_mismatch("reply_len", 32'(got.len), 32'(want.len));
                if (got.value !== want.value)
                    report_mismatch("reply_value", 32'(got.value), 32'(want.value));
                if (got.out_left !== want.out_left)
                    report_mismatch("out_left", {16'd0, got.out_left}, {16'd0, want.out_left});
                if (got.out_right !== want.out_right)
                    report_mismatch("out_right", {16'd0, got.out_right},
                                    {16'd0, want.out_right});
            end
        end
    end

endmodule

/* filelist.f */
hw/rtl/uafu_pkg.sv
hw/rtl/uafu_req.sv
hw/rtl/uafu_lane.sv
hw/rtl/uafu_merge.sv
hw/rtl/usb_audio_feature_unit.sv
tb/usb_audio_feature_unit_tb.sv
